// File: rtl/core/wsd_pkg.sv
// Shared types and codes for the WebSocket frame deframer.
// Used by wsd_step, websocket_frame_deframer and wsd_checker; depends on nothing.
package wsd_pkg;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_ERR  = 3'd5;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_OVERSIZE = 2'd2;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4080;

  // Parser state. Any accepted length fits in 16 bits; len_hi records that
  // some byte shifted above bit 15 of the extended length was nonzero.
  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  opcode;
    logic        masked;
    logic [15:0] len;
    logic        len_hi;
    logic [2:0]  ext_left;
    logic [31:0] key;
    logic [1:0]  mphase;
  } wsd_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } wsd_result_t;

endpackage

// File: rtl/core/wsd_step.sv
// Per-byte parser update: next state and optional result for one received byte.
// Purely combinational; depends on wsd_pkg.
module wsd_step (
  input  wsd_pkg::wsd_state_t  cur,
  input  logic [7:0]           in_byte,
  input  logic                 new_conn,
  input  logic [15:0]          max_payload,
  output wsd_pkg::wsd_state_t  nxt,
  output wsd_pkg::wsd_result_t res
);

  wsd_pkg::wsd_state_t st;
  logic [6:0]  len7;
  logic        do_len;
  logic        do_begin;
  logic [7:0]  key_byte;
  logic [15:0] len_dec;

  assign len7 = in_byte[6:0];

  always_comb begin
    st = cur;
    if (new_conn) begin
      st = '0;
      st.phase = wsd_pkg::PH_HDR0;
    end
    nxt      = st;
    res      = '0;
    do_len   = 1'b0;
    do_begin = 1'b0;
    key_byte = st.masked ? st.key[5'd31 - {st.mphase, 3'b000} -: 8] : 8'h00;
    len_dec  = st.len - 16'd1;

    case (st.phase)
      wsd_pkg::PH_HDR0: begin
        nxt.opcode = in_byte[3:0];
        nxt.phase  = wsd_pkg::PH_HDR1;
      end
      wsd_pkg::PH_HDR1: begin
        nxt.masked = in_byte[7];
        if (len7 inside {wsd_pkg::LEN7_EXT16, wsd_pkg::LEN7_EXT64}) begin
          nxt.len      = '0;
          nxt.len_hi   = 1'b0;
          nxt.ext_left = (len7 == wsd_pkg::LEN7_EXT16) ? 3'd1 : 3'd7;
          nxt.phase    = wsd_pkg::PH_EXT;
        end else begin
          nxt.len    = {9'd0, len7};
          nxt.len_hi = 1'b0;
          do_len     = 1'b1;
        end
      end
      wsd_pkg::PH_EXT: begin
        nxt.len    = {st.len[7:0], in_byte};
        nxt.len_hi = st.len_hi | (st.len[15:8] != 8'd0);
        if (st.ext_left == 3'd0) begin
          do_len = 1'b1;
        end else begin
          nxt.ext_left = st.ext_left - 3'd1;
        end
      end
      wsd_pkg::PH_MASK: begin
        nxt.key = {st.key[23:0], in_byte};
        if (st.ext_left == 3'd0) begin
          do_begin = 1'b1;
        end else begin
          nxt.ext_left = st.ext_left - 3'd1;
        end
      end
      wsd_pkg::PH_DATA: begin
        nxt.mphase = st.mphase + 2'd1;
        nxt.len    = len_dec;
        res.valid  = 1'b1;
        res.kind   = wsd_pkg::KIND_DATA;
        res.data   = in_byte ^ key_byte;
        res.opcode = st.opcode;
        res.last   = (len_dec == 16'd0);
        if (len_dec == 16'd0) begin
          nxt.phase = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        // Error phase: bytes are dropped until a new connection starts.
      end
    endcase

    // The length is complete: check the limit, then go to the key or the payload.
    if (do_len) begin
      if (nxt.len_hi || (nxt.len > max_payload)) begin
        nxt.phase  = wsd_pkg::PH_ERR;
        res.valid  = 1'b1;
        res.kind   = wsd_pkg::KIND_OVERSIZE;
        res.opcode = nxt.opcode;
      end else if (nxt.masked) begin
        nxt.phase    = wsd_pkg::PH_MASK;
        nxt.ext_left = 3'd3;
        nxt.key      = '0;
      end else begin
        do_begin = 1'b1;
      end
    end

    if (do_begin) begin
      nxt.mphase = 2'd0;
      if (nxt.len == 16'd0) begin
        nxt.phase  = wsd_pkg::PH_HDR0;
        res.valid  = 1'b1;
        res.kind   = wsd_pkg::KIND_EMPTY;
        res.opcode = nxt.opcode;
        res.last   = 1'b1;
      end else begin
        nxt.phase = wsd_pkg::PH_DATA;
      end
    end
  end

endmodule

// File: rtl/core/websocket_frame_deframer.sv
// WebSocket frame deframer top level: parser state, limit register, result register.
// Depends on wsd_pkg and wsd_step.
//
// The block takes one byte of a connection stream per cycle and delivers at
// most one result per byte: an unmasked payload byte tagged with its frame's
// opcode, an empty-frame marker, or an oversize error after which bytes are
// dropped until one arrives with in_new_connection set. Every byte is parsed
// in the cycle it is accepted and its result appears on the out_ port in the
// following cycle, so the sustained rate is one byte per clock while out_ready
// stays high. The only thing that holds the input back is the single result
// register: in_ready is low only while a result is waiting and out_ready is
// low. The max_payload limit is written through the cfg_ port, which is always
// ready, and should only be changed while no bytes are in flight.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_new_connection,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_data_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_payload
);

  wsd_pkg::wsd_state_t  state_r;
  wsd_pkg::wsd_state_t  state_nxt;
  wsd_pkg::wsd_result_t res_nxt;
  logic [15:0]          max_payload_r;
  logic                 out_valid_r;
  logic [1:0]           kind_r;
  logic [7:0]           data_r;
  logic [3:0]           opcode_r;
  logic                 last_r;
  logic                 in_xfer;

  wsd_step u_step (
    .cur         (state_r),
    .in_byte     (in_byte),
    .new_conn    (in_new_connection),
    .max_payload (max_payload_r),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= wsd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  // The all-zero state is the first header byte of a fresh connection.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= res_nxt.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of the result register needs no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r   <= res_nxt.kind;
      data_r   <= res_nxt.data;
      opcode_r <= res_nxt.opcode;
      last_r   <= res_nxt.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_data_byte    = data_r;
  assign out_frame_opcode = opcode_r;
  assign out_last         = last_r;

endmodule

// File: rtl/core/wsd_checker.sv
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer.
module wsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_result_kind,
  input logic [7:0] out_data_byte,
  input logic [3:0] out_frame_opcode,
  input logic       out_last
);

  // A result waiting on a stalled output keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_data_byte) && $stable(out_frame_opcode) && $stable(out_last))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind == wsd_pkg::KIND_DATA ||
      out_result_kind == wsd_pkg::KIND_EMPTY || out_result_kind == wsd_pkg::KIND_OVERSIZE)
    else $error("illegal result kind");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != wsd_pkg::KIND_DATA |-> out_data_byte == 8'd0)
    else $error("nonzero data on a non-payload result");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind != wsd_pkg::KIND_EMPTY || out_last) &&
      (out_result_kind != wsd_pkg::KIND_OVERSIZE || !out_last))
    else $error("last flag inconsistent with result kind");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_kind  (out_result_kind),
  .out_data_byte    (out_data_byte),
  .out_frame_opcode (out_frame_opcode),
  .out_last         (out_last)
);
